/* rtl/fixed_block_free_list_allocator_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the fixed block free list allocator
// Checks are clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define FBFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FBFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fbfa_pkg.sv */
// ----------------------------------------------------------------------------
// fbfa_pkg
// Shared types and constants of the block pool allocator.
// ----------------------------------------------------------------------------
package fbfa_pkg;

  // fixed field widths
  localparam int BB_W      = 16;  // block size register
  localparam int BC_W      = 9;   // block count register
  localparam int IDX_OUT_W = 8;   // block_index result field
  localparam int CNT_OUT_W = 9;   // free_blocks result field
  localparam int STS_W     = 2;

  // configuration register indexes
  localparam logic REG_BLOCK_BYTES = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // result status codes
  localparam logic [STS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_MEM   = 2'd1;
  localparam logic [STS_W-1:0] STS_BAD_ADDR = 2'd2;
  localparam logic [STS_W-1:0] STS_FULL     = 2'd3;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* rtl/fbfa_div.sv */
// ----------------------------------------------------------------------------
// fbfa_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbfa_div import fbfa_pkg::*; #(
  parameter int N_W = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [N_W-1:0]  dividend,
  input  logic [BB_W-1:0] divisor,
  output div_sts_t        sts,
  output logic [N_W-1:0]  quot,
  output logic [BB_W-1:0] rem
);

  localparam int CW = $clog2(N_W + 1);

  logic [N_W-1:0]  quo_r, quo_nxt;
  logic [BB_W-1:0] rem_r, rem_nxt;
  logic [BB_W-1:0] dsr_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;
  logic [BB_W:0]   shifted, diff;
  logic            ge;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    shifted = {rem_r, quo_r[N_W-1]};
    ge      = shifted >= {1'b0, dsr_r};
    diff    = shifted - {1'b0, dsr_r};
    rem_nxt = ge ? diff[BB_W-1:0] : shifted[BB_W-1:0];
    quo_nxt = {quo_r[N_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = quo_r;
  assign rem      = rem_r;

endmodule

/* rtl/fixed_block_free_list_allocator_core.sv */
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// Pool allocator for equal-size blocks with a circular free list.
// ----------------------------------------------------------------------------
// One request word in, one result word out. An allocate is a ring read,
// then a bit-serial multiply of the index by the block size, one index bit
// a cycle. A free runs the serial divider that turns the offset into an
// index, one bit a cycle. Requests answered at once (out of memory, a free
// with zero block size) go straight to the output register.
// A new request is taken while the previous result still waits at the output.
// Writing block_count reloads the list in the same cycle; no clearing pass.
// The user must write registers only while no request is in flight; the
// core itself does not enforce this.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core import fbfa_pkg::*; #(
  parameter int MAX_BLOCKS  = 256,
  parameter int OFFSET_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic [BB_W-1:0]        cfg_wdata,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [((OFFSET_BITS+7)/8)*8-1:0] in_tdata,  // free_offset
  input  logic                   in_tuser,            // req_type
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [((OFFSET_BITS+IDX_OUT_W+CNT_OUT_W+7)/8)*8-1:0] out_tdata,
                                 // block_offset, block_index, free_blocks
  output logic [STS_W-1:0]       out_tuser             // status
);

  `include "fixed_block_free_list_allocator_core_macros.svh"

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int MC_W    = $clog2(IDX_W + 1);
  localparam int OUT_DW  = ((OFFSET_BITS + IDX_OUT_W + CNT_OUT_W + 7) / 8) * 8;
  localparam int IX_W    = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
  localparam int CX_W    = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam int QX_W    = (OFFSET_BITS > CNT_W) ? OFFSET_BITS : CNT_W;
  localparam int EFF_RST = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ARD  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [BB_W-1:0]        bb_r;
  logic [CNT_W-1:0]       eff_r, eff_nxt;
  logic [IDX_W-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;

  logic [STS_W-1:0]       res_sts_r, res_sts_nxt;
  logic [OFFSET_BITS-1:0] res_off_r, res_off_nxt;
  logic [IDX_W-1:0]       res_idx_r, res_idx_nxt;

  logic [OFFSET_BITS-1:0] acc_r, acc_nxt, acc_step;
  logic [IDX_W-1:0]       mul_idx_r, mul_idx_nxt;
  logic [MC_W-1:0]        mul_cnt_r, mul_cnt_nxt;

  logic [IDX_W-1:0]       ring_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]       rd_data_r;
  logic                   mem_rd;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [IDX_W-1:0]       mem_wdata;

  logic                   out_valid_r;
  logic [STS_W-1:0]       out_sts_r;
  logic [OFFSET_BITS-1:0] out_off_r;
  logic [IDX_OUT_W-1:0]   out_idx_r;
  logic [CNT_OUT_W-1:0]   out_cnt_r;
  logic                   out_load;

  logic                   in_acc;
  logic                   div_start;
  div_sts_t               div_sts;
  logic [OFFSET_BITS-1:0] div_quot;
  logic [BB_W-1:0]        div_rem;

  logic [IDX_W-1:0]       pop_idx;
  logic [CNT_W-1:0]       head_inc;
  logic [CNT_W:0]         tail_sum;
  logic [CNT_W:0]         tail_wrap;
  logic [QX_W-1:0]        quot_ext;
  logic                   div_bad;
  logic [IX_W-1:0]        idx_ext;
  logic [CX_W-1:0]        cnt_ext;
  logic [CNT_W-1:0]       cfg_cnt;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // block count write, clamped to between 2 and the pool size
  always_comb begin
    if (cfg_wdata[BC_W-1:0] < BC_W'(2)) begin
      cfg_cnt = CNT_W'(2);
    end else if (32'(cfg_wdata[BC_W-1:0]) > 32'(MAX_BLOCKS)) begin
      cfg_cnt = CNT_W'(MAX_BLOCKS);
    end else begin
      cfg_cnt = CNT_W'(cfg_wdata[BC_W-1:0]);
    end
  end

  // ring entry at the head: never-written positions hold their own index
  assign pop_idx  = (CNT_W'(head_r) < fill_r) ? rd_data_r : head_r;
  assign head_inc = CNT_W'(head_r) + CNT_W'(1);

  // tail position, head plus count below twice the list length
  assign tail_sum  = {1'b0, CNT_W'(head_r)} + {1'b0, total_r};
  assign tail_wrap = (tail_sum >= {1'b0, eff_r}) ? tail_sum - {1'b0, eff_r} : tail_sum;

  // divider verdict
  assign quot_ext = QX_W'(div_quot);
  assign div_bad  = (div_rem != '0) || (quot_ext >= QX_W'(eff_r));

  // shift-add multiply step, index msb first
  assign acc_step = {acc_r[OFFSET_BITS-2:0], 1'b0} +
                    (mul_idx_r[IDX_W-1] ? OFFSET_BITS'(bb_r) : '0);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    total_nxt   = total_r;
    fill_nxt    = fill_r;
    eff_nxt     = eff_r;
    res_sts_nxt = res_sts_r;
    res_off_nxt = res_off_r;
    res_idx_nxt = res_idx_r;
    acc_nxt     = acc_r;
    mul_idx_nxt = mul_idx_r;
    mul_cnt_nxt = mul_cnt_r;
    mem_rd      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = tail_wrap[IDX_W-1:0];
    mem_wdata   = quot_ext[IDX_W-1:0];
    div_start   = 1'b0;
    out_load    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_sts_nxt = STS_OK;
          res_off_nxt = '0;
          res_idx_nxt = '0;
          if (!in_tuser) begin
            if (total_r == '0) begin
              res_sts_nxt = STS_NO_MEM;
              state_nxt   = S_OUT;
            end else begin
              mem_rd    = 1'b1;
              state_nxt = S_ARD;
            end
          end else if (bb_r == '0) begin
            res_sts_nxt = STS_BAD_ADDR;
            state_nxt   = S_OUT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_ARD: begin
        // pop the head entry
        res_idx_nxt = pop_idx;
        mul_idx_nxt = pop_idx;
        acc_nxt     = '0;
        mul_cnt_nxt = MC_W'(IDX_W);
        head_nxt    = (head_inc == eff_r) ? '0 : head_inc[IDX_W-1:0];
        total_nxt   = total_r - CNT_W'(1);
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        acc_nxt     = acc_step;
        mul_idx_nxt = mul_idx_r << 1;
        mul_cnt_nxt = mul_cnt_r - MC_W'(1);
        if (mul_cnt_r == MC_W'(1)) begin
          res_off_nxt = acc_step;
          state_nxt   = S_OUT;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_OUT;
          if (div_bad) begin
            res_sts_nxt = STS_BAD_ADDR;
          end else begin
            res_idx_nxt = quot_ext[IDX_W-1:0];
            if (total_r >= eff_r) begin
              res_sts_nxt = STS_FULL;
            end else begin
              // push at the tail; writes fill positions from zero upward
              mem_we    = 1'b1;
              total_nxt = total_r + CNT_W'(1);
              if (fill_r < eff_r) begin
                fill_nxt = fill_r + CNT_W'(1);
              end
            end
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // block count write reloads the list
    if (cfg_we && (cfg_addr == REG_BLOCK_COUNT)) begin
      eff_nxt   = cfg_cnt;
      head_nxt  = '0;
      total_nxt = cfg_cnt;
      fill_nxt  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bb_r        <= BB_W'(64);
      eff_r       <= CNT_W'(EFF_RST);
      head_r      <= '0;
      total_r     <= CNT_W'(EFF_RST);
      fill_r      <= '0;
      mul_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      eff_r     <= eff_nxt;
      head_r    <= head_nxt;
      total_r   <= total_nxt;
      fill_r    <= fill_nxt;
      mul_cnt_r <= mul_cnt_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_BLOCK_BYTES: bb_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_sts_r <= res_sts_nxt;
    res_off_r <= res_off_nxt;
    res_idx_r <= res_idx_nxt;
    acc_r     <= acc_nxt;
    mul_idx_r <= mul_idx_nxt;
  end

  // free ring memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_rd) begin
      rd_data_r <= ring_mem[head_r];
    end
  end

  // output register
  assign idx_ext = IX_W'(res_idx_r);
  assign cnt_ext = CX_W'(total_r);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sts_r <= res_sts_r;
      out_off_r <= res_off_r;
      out_idx_r <= idx_ext[IDX_OUT_W-1:0];
      out_cnt_r <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sts_r;
  assign out_tdata  = OUT_DW'({out_cnt_r, out_idx_r, out_off_r});

  // offset to index
  fbfa_div #(
    .N_W (OFFSET_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_tdata[OFFSET_BITS-1:0]),
    .divisor  (bb_r),
    .sts      (div_sts),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // checks
  `FBFA_ASSERT_NOW(a_total_le_len, 1'b1, total_r <= eff_r, "free count above list length")
  `FBFA_ASSERT_NOW(a_head_in_list, 1'b1, CNT_W'(head_r) < eff_r, "head outside the list")
  `FBFA_ASSERT_NOW(a_div_start_idle, div_start, !div_sts.busy, "divider restarted while busy")
  `FBFA_ASSERT_NEXT(a_accept_busy, in_acc, !in_tready, "request taken while one in flight")

endmodule

/* dv/tb_fixed_block_free_list_allocator_core.sv */
// ----------------------------------------------------------------------------
// tb_fixed_block_free_list_allocator_core
// Self-checking bench for the block pool allocator. A directed table covers
// reset state, list reloads, out of memory, bad and full frees and the size
// extremes. Random phases then mix allocates and frees under several
// configurations, with random idle cycles on both streams. Every result word
// is checked against its directed row or else a model of the ring free list.
// ----------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator_core import fbfa_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFF_W       = 24;
  localparam int RING_DEPTH  = 256;
  localparam int N_DIRECTED  = 28;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 50;

  typedef enum logic {REQ_ALLOC = 1'b0, REQ_FREE = 1'b1} req_kind_t;

  typedef struct packed {
    logic [STS_W-1:0]     status;
    logic [OFF_W-1:0]     blk_offset;
    logic [IDX_OUT_W-1:0] blk_index;
    logic [CNT_OUT_W-1:0] free_blocks;
  } alloc_result_t;

  // one directed row: either a register write or a request
  typedef struct packed {
    logic          is_cfg;
    logic          cfg_reg;
    logic [15:0]   cfg_val;
    req_kind_t     kind;
    logic [OFF_W-1:0] offset;
    logic          typed;
    alloc_result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [BB_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;  // free_offset
  logic in_tuser = 1'b0;       // req_type
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;      // block_offset, block_index, free_blocks
  logic [STS_W-1:0] out_tuser; // status

  fixed_block_free_list_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // pool model state
  logic [7:0]  free_idx_ring [RING_DEPTH];
  int unsigned ring_head;
  int unsigned free_total;
  int unsigned live_count;
  logic [15:0] bytes_per_block;
  logic [8:0]  count_reg;

  alloc_result_t pending_results [$];
  alloc_result_t got, want_now;
  bit failed = 1'b0;
  bit calm = 1'b0;   // no idling on either side while set
  plan_row_t directed_plan [N_DIRECTED];

  // reload the ring with 0..N-1, count clamped to the legal range
  function automatic void reload_free_list();
    int unsigned n;
    n = count_reg;
    if (n < 2) n = 2;
    if (n > RING_DEPTH) n = RING_DEPTH;
    live_count = n;
    for (int i = 0; i < RING_DEPTH; i++) free_idx_ring[i] = (i < n) ? 8'(i) : 8'd0;
    ring_head = 0;
    free_total = n;
  endfunction

  // advance the pool model by one request and return its result word
  function automatic alloc_result_t predict_request(req_kind_t kind, logic [OFF_W-1:0] off);
    alloc_result_t r;
    int unsigned h, t, q, ofs, bb, prod;
    r = '0;
    r.status = STS_OK;
    ofs = off;
    bb = bytes_per_block;
    if (kind == REQ_ALLOC) begin
      if (free_total == 0) begin
        r.status = STS_NO_MEM;
      end else begin
        h = ring_head % live_count;
        r.blk_index = free_idx_ring[h];
        prod = r.blk_index * bb;
        r.blk_offset = prod[OFF_W-1:0];
        ring_head = (h + 1) % live_count;
        free_total--;
      end
    end else begin
      if (bb == 0 || (ofs % bb) != 0 || (ofs / bb) >= live_count) begin
        r.status = STS_BAD_ADDR;
      end else begin
        q = ofs / bb;
        r.blk_index = q[7:0];
        if (free_total >= live_count) begin
          r.status = STS_FULL;
        end else begin
          t = (ring_head + free_total) % live_count;
          free_idx_ring[t] = q[7:0];
          free_total++;
        end
      end
    end
    r.free_blocks = free_total[8:0];
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic reg_sel, logic [15:0] val);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_reg = reg_sel;
    row.cfg_val = val;
    return row;
  endfunction

  function automatic plan_row_t req_row(req_kind_t kind, logic [OFF_W-1:0] off, logic typed,
                                        logic [STS_W-1:0] sts, logic [OFF_W-1:0] b_off,
                                        logic [7:0] b_idx, logic [8:0] n_free);
    plan_row_t row;
    row = '0;
    row.kind = kind;
    row.offset = off;
    row.typed = typed;
    row.want = '{sts, b_off, b_idx, n_free};
    return row;
  endfunction

  // drop valid and wait until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic reg_sel, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= reg_sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (reg_sel == REG_BLOCK_BYTES) begin
      bytes_per_block = val;
    end else begin
      count_reg = val[8:0];
      reload_free_list();
    end
  endtask

  // drive one request word; queue its expected result on acceptance
  task automatic send_req(req_kind_t kind, logic [OFF_W-1:0] off, logic typed,
                          alloc_result_t want);
    alloc_result_t r;
    while (!calm && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= off;
    do @(posedge clk); while (!in_tready);
    r = predict_request(kind, off);
    pending_results.push_back(typed ? want : r);
  endtask

  // random word: mostly allocates and aligned frees, some broken frees
  task automatic send_random();
    int unsigned pick, idx, off;
    pick = $urandom_range(99);
    idx = $urandom_range(live_count - 1);
    off = idx * bytes_per_block;
    if (pick < 45) begin
      send_req(REQ_ALLOC, OFF_W'($urandom), 1'b0, '0);
    end else if (pick < 80) begin
      send_req(REQ_FREE, OFF_W'(off), 1'b0, '0);
    end else if (pick < 88) begin
      send_req(REQ_FREE, OFF_W'(off + $urandom_range(1, 3)), 1'b0, '0);
    end else if (pick < 94) begin
      off = (live_count + $urandom_range(7)) * bytes_per_block;
      send_req(REQ_FREE, OFF_W'(off), 1'b0, '0);
    end else begin
      send_req(REQ_FREE, OFF_W'($urandom), 1'b0, '0);
    end
  endtask

  // result side: random stalls, compare each word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[23:0], out_tdata[31:24], out_tdata[40:32]};
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        failed = 1'b1;
      end else begin
        want_now = pending_results.pop_front();
        if (got.status !== want_now.status) begin
          $error("status expected %0d got %0d", want_now.status, got.status);
          failed = 1'b1;
        end
        if (got.blk_offset !== want_now.blk_offset) begin
          $error("block_offset expected %0h got %0h", want_now.blk_offset, got.blk_offset);
          failed = 1'b1;
        end
        if (got.blk_index !== want_now.blk_index) begin
          $error("block_index expected %0d got %0d", want_now.blk_index, got.blk_index);
          failed = 1'b1;
        end
        if (got.free_blocks !== want_now.free_blocks) begin
          $error("free_blocks expected %0d got %0d", want_now.free_blocks, got.free_blocks);
          failed = 1'b1;
        end
      end
    end
    out_tready <= calm || ($urandom_range(99) >= 27);
  end

  // main sequence
  initial begin
    bytes_per_block = 16'd64;
    count_reg = 9'd256;
    reload_free_list();

    directed_plan = '{
      // reset state: 64-byte blocks, 256 of them
      req_row(REQ_ALLOC, 24'h000000, 1'b1, STS_OK, 24'h000000, 8'd0, 9'd255),
      req_row(REQ_ALLOC, 24'h000000, 1'b1, STS_OK, 24'h000040, 8'd1, 9'd254),
      req_row(REQ_FREE,  24'h000040, 1'b1, STS_OK, 24'h000000, 8'd1, 9'd255),
      req_row(REQ_FREE,  24'h000001, 1'b1, STS_BAD_ADDR, 24'h000000, 8'd0, 9'd255),
      req_row(REQ_FREE,  24'hFFFFFF, 1'b1, STS_BAD_ADDR, 24'h000000, 8'd0, 9'd255),
      req_row(REQ_FREE,  24'h004000, 1'b1, STS_BAD_ADDR, 24'h000000, 8'd0, 9'd255),
      req_row(REQ_FREE,  24'h000000, 1'b1, STS_OK, 24'h000000, 8'd0, 9'd256),
      req_row(REQ_FREE,  24'h003FC0, 1'b1, STS_FULL, 24'h000000, 8'd255, 9'd256),
      // two-block pool: run dry, then refill
      cfg_row(REG_BLOCK_COUNT, 16'd2),
      req_row(REQ_ALLOC, 24'h000000, 1'b1, STS_OK, 24'h000000, 8'd0, 9'd1),
      req_row(REQ_ALLOC, 24'h000000, 1'b1, STS_OK, 24'h000040, 8'd1, 9'd0),
      req_row(REQ_ALLOC, 24'h000000, 1'b1, STS_NO_MEM, 24'h000000, 8'd0, 9'd0),
      req_row(REQ_FREE,  24'h000040, 1'b1, STS_OK, 24'h000000, 8'd1, 9'd1),
      req_row(REQ_ALLOC, 24'h000000, 1'b0, '0, '0, '0, '0),
      // zero block size
      cfg_row(REG_BLOCK_BYTES, 16'd0),
      req_row(REQ_FREE,  24'h000000, 1'b1, STS_BAD_ADDR, 24'h000000, 8'd0, 9'd0),
      req_row(REQ_ALLOC, 24'h000000, 1'b1, STS_NO_MEM, 24'h000000, 8'd0, 9'd0),
      cfg_row(REG_BLOCK_COUNT, 16'd0),
      req_row(REQ_ALLOC, 24'h000000, 1'b1, STS_OK, 24'h000000, 8'd0, 9'd1),
      req_row(REQ_ALLOC, 24'h000000, 1'b1, STS_OK, 24'h000000, 8'd1, 9'd0),
      // largest block, count above the maximum clamps to 256
      cfg_row(REG_BLOCK_BYTES, 16'hFFFF),
      cfg_row(REG_BLOCK_COUNT, 16'd511),
      req_row(REQ_ALLOC, 24'h000000, 1'b1, STS_OK, 24'h000000, 8'd0, 9'd255),
      req_row(REQ_ALLOC, 24'h000000, 1'b1, STS_OK, 24'h00FFFF, 8'd1, 9'd254),
      req_row(REQ_FREE,  24'hFEFF01, 1'b1, STS_OK, 24'h000000, 8'd255, 9'd255),
      req_row(REQ_FREE,  24'hFFFF00, 1'b1, STS_BAD_ADDR, 24'h000000, 8'd0, 9'd255),
      // count below the minimum clamps to 2; list starts full
      cfg_row(REG_BLOCK_COUNT, 16'd1),
      req_row(REQ_FREE,  24'h000000, 1'b1, STS_FULL, 24'h000000, 8'd0, 9'd2)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        write_reg(directed_plan[i].cfg_reg, directed_plan[i].cfg_val);
      end else begin
        send_req(directed_plan[i].kind, directed_plan[i].offset, directed_plan[i].typed,
                 directed_plan[i].want);
      end
    end

    // random phases; phase 3 runs without idling
    for (int p = 0; p < N_PHASES; p++) begin
      calm = (p == 3);
      case (p)
        0: begin write_reg(REG_BLOCK_BYTES, 16'd16);    write_reg(REG_BLOCK_COUNT, 16'd256); end
        1: begin write_reg(REG_BLOCK_BYTES, 16'd1);     write_reg(REG_BLOCK_COUNT, 16'd8); end
        2: begin write_reg(REG_BLOCK_BYTES, 16'hFFFF);  write_reg(REG_BLOCK_COUNT, 16'd256); end
        3: begin write_reg(REG_BLOCK_BYTES, 16'd3);     write_reg(REG_BLOCK_COUNT, 16'd2); end
        4: begin write_reg(REG_BLOCK_BYTES, 16'd40000); write_reg(REG_BLOCK_COUNT, 16'd100); end
        5: begin write_reg(REG_BLOCK_BYTES, 16'd0);     write_reg(REG_BLOCK_COUNT, 16'd5); end
        6: begin write_reg(REG_BLOCK_BYTES, 16'd2);     write_reg(REG_BLOCK_COUNT, 16'd300); end
        default: begin
          write_reg(REG_BLOCK_BYTES, 16'($urandom_range(1, 1000)));
          write_reg(REG_BLOCK_COUNT, 16'($urandom_range(2, 40)));
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // size change mid-phase keeps the free list
        if (k == PHASE_ITEMS / 2 && $urandom_range(1) == 1)
          write_reg(REG_BLOCK_BYTES, $urandom_range(1) ? 16'($urandom_range(1, 64))
                                                       : 16'($urandom_range(65535)));
        send_random();
      end
    end
    calm = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
